// ===== rtl/mcos_pkg.sv =====
// ----------------------------------------------------------------------------
// mcos_pkg
// Shared types, widths, register indexes and helper functions for the
// midpoint circle octant stepper.
// ----------------------------------------------------------------------------
package mcos_pkg;

  // Width of the octant offsets x and y.
  localparam int COORD_BITS = 12;

  // Decision variable, scaled by four, two's complement.
  localparam int DEC_W = 18;

  // Configuration register widths.
  localparam int CENTER_W  = 12;
  localparam int RADIUS_W  = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

  // Pixel coordinates leave as 14-bit two's complement values. The sums are
  // formed modulo 2^SUM_W, which keeps the low PIX_W bits exact.
  localparam int PIX_W = 14;
  localparam int SUM_W = (COORD_BITS > PIX_W) ? COORD_BITS : PIX_W;

  // Eight symmetric points per step.
  localparam int               PT_W       = 3;
  localparam logic [PT_W-1:0]  FIRST_POINT = 3'd0;
  localparam logic [PT_W-1:0]  LAST_POINT  = 3'd7;

  // Step queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified step: the offset to emit and the completion flag.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  done;
  } step_t;

  // Offset times eight, zero-extended to the decision width.
  function automatic logic [DEC_W-1:0] times8(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+2:0] w;
    w = {v, 3'b000};
    return DEC_W'(w);
  endfunction

  // Offset times four, zero-extended to the decision width.
  function automatic logic [DEC_W-1:0] times4(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+1:0] w;
    w = {v, 2'b00};
    return DEC_W'(w);
  endfunction

endpackage

// ===== rtl/mcos_front.sv =====
// ----------------------------------------------------------------------------
// mcos_front
// Takes step requests, applies a restart if asked, and advances the octant
// state by one midpoint step per request. The offset to draw and the done
// flag are handed to the step queue.
// ----------------------------------------------------------------------------
module mcos_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  input  logic [mcos_pkg::RADIUS_W-1:0]  radius,
  output logic                           push_valid,
  input  logic                           push_ready,
  output mcos_pkg::step_t                push_data
);

  logic [mcos_pkg::COORD_BITS-1:0] offset_x_r, offset_x_nxt;
  logic [mcos_pkg::COORD_BITS-1:0] offset_y_r, offset_y_nxt;
  logic [mcos_pkg::DEC_W-1:0]      decision_r, decision_nxt;

  logic [mcos_pkg::COORD_BITS-1:0] y_load;
  logic [mcos_pkg::DEC_W-1:0]      d_load;
  logic [mcos_pkg::COORD_BITS-1:0] x_cur, y_cur;
  logic [mcos_pkg::DEC_W-1:0]      d_cur, d_mid;
  logic                            d_pos;
  logic                            accept;

  // A request is taken whenever the queue has room.
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Restart values and one midpoint step.
  always_comb begin
    y_load = mcos_pkg::COORD_BITS'(radius);
    d_load = mcos_pkg::DEC_W'(5) - mcos_pkg::times4(y_load);

    x_cur = in_restart ? '0 : offset_x_r;
    y_cur = in_restart ? y_load : offset_y_r;
    d_cur = in_restart ? d_load : decision_r;

    d_pos = !d_cur[mcos_pkg::DEC_W-1] && (d_cur != '0);

    if (d_pos) begin
      offset_y_nxt = y_cur - mcos_pkg::COORD_BITS'(1);
      d_mid        = d_cur - mcos_pkg::times8(offset_y_nxt);
    end else begin
      offset_y_nxt = y_cur;
      d_mid        = d_cur;
    end

    offset_x_nxt = x_cur + mcos_pkg::COORD_BITS'(1);
    decision_nxt = d_mid + mcos_pkg::times8(offset_x_nxt) + mcos_pkg::DEC_W'(4);

    push_data.x    = x_cur;
    push_data.y    = y_cur;
    push_data.done = offset_x_nxt > offset_y_nxt;
  end

  // Octant state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      decision_r <= '0;
    end else if (accept) begin
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
      decision_r <= decision_nxt;
    end
  end

endmodule

// ===== rtl/mcos_queue.sv =====
// ----------------------------------------------------------------------------
// mcos_queue
// Small FIFO of classified steps between the front and back parts, so each
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module mcos_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mcos_pkg::step_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mcos_pkg::step_t pop_data
);

  mcos_pkg::step_t mem [mcos_pkg::QDEPTH];

  logic [mcos_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mcos_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mcos_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        push, pop;

  assign push_ready = (count_r != mcos_pkg::QCNT_W'(mcos_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mcos_pkg::QPTR_W'(mcos_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + mcos_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcos_pkg::QPTR_W'(mcos_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + mcos_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + mcos_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - mcos_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mcos_pkg::QCNT_W'(mcos_pkg::QDEPTH))
    else $error("step queue count exceeds depth");

endmodule

// ===== rtl/mcos_back.sv =====
// ----------------------------------------------------------------------------
// mcos_back
// Pulls one step at a time from the queue and emits its eight symmetric
// points around the center, one per cycle while out_ready is high, through an output register.
// ----------------------------------------------------------------------------
module mcos_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  mcos_pkg::step_t                     pop_data,
  input  logic [mcos_pkg::CENTER_W-1:0]       center_x,
  input  logic [mcos_pkg::CENTER_W-1:0]       center_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mcos_pkg::PIX_W-1:0]   out_pixel_x,
  output logic signed [mcos_pkg::PIX_W-1:0]   out_pixel_y,
  output logic                                out_last,
  output logic                                out_done_res
);

  // Step being drawn.
  logic                            work_valid_r, work_valid_nxt;
  mcos_pkg::step_t                 work_r;
  logic [mcos_pkg::PT_W-1:0]       idx_r, idx_nxt;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [mcos_pkg::PIX_W-1:0]      pix_x_r, pix_y_r;
  logic                            last_r, done_r;

  logic                            out_load, pop;
  logic [mcos_pkg::COORD_BITS-1:0] a_off, b_off;
  logic [mcos_pkg::SUM_W-1:0]      sum_x, sum_y;

  assign out_load  = work_valid_r && (!out_valid_r || out_ready);
  assign pop_ready = !work_valid_r || (out_load && idx_r == mcos_pkg::LAST_POINT);
  assign pop       = pop_valid && pop_ready;

  // Point selection: bit 2 swaps x and y, bit 0 negates the horizontal
  // term, bit 1 makes the vertical term positive.
  always_comb begin
    a_off = idx_r[2] ? work_r.y : work_r.x;
    b_off = idx_r[2] ? work_r.x : work_r.y;
    sum_x = idx_r[0] ?
            mcos_pkg::SUM_W'(center_x) - mcos_pkg::SUM_W'(a_off) :
            mcos_pkg::SUM_W'(center_x) + mcos_pkg::SUM_W'(a_off);
    sum_y = idx_r[1] ?
            mcos_pkg::SUM_W'(center_y) + mcos_pkg::SUM_W'(b_off) :
            mcos_pkg::SUM_W'(center_y) - mcos_pkg::SUM_W'(b_off);
  end

  // Control next state.
  always_comb begin
    work_valid_nxt = work_valid_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + mcos_pkg::PT_W'(1);
      if (idx_r == mcos_pkg::LAST_POINT) begin
        work_valid_nxt = 1'b0;
      end
    end
    if (pop) begin
      work_valid_nxt = 1'b1;
      idx_nxt        = mcos_pkg::FIRST_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      idx_r        <= mcos_pkg::FIRST_POINT;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      work_r <= pop_data;
    end
    if (out_load) begin
      pix_x_r <= sum_x[mcos_pkg::PIX_W-1:0];
      pix_y_r <= sum_y[mcos_pkg::PIX_W-1:0];
      last_r  <= (idx_r == mcos_pkg::LAST_POINT);
      done_r  <= work_r.done;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = pix_x_r;
  assign out_pixel_y  = pix_y_r;
  assign out_last     = last_r;
  assign out_done_res = done_r;

  // A waiting last point means the point counter has wrapped to the start.
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> idx_r == mcos_pkg::FIRST_POINT)
    else $error("last point shown while point counter is mid-step");

  // A fresh step always starts at the first point.
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> work_valid_r && idx_r == mcos_pkg::FIRST_POINT)
    else $error("new step did not start at the first point");

  // With no step in hand the point counter rests at the start.
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !work_valid_r |-> idx_r == mcos_pkg::FIRST_POINT)
    else $error("point counter moved without a step");

endmodule

// ===== rtl/midpoint_circle_octant_step.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_octant_step
// Midpoint circle rasterizer that draws one octant step per request.
//
// Each request on the in_ channel (in_valid/in_ready, field in_restart)
// advances the arc by one step; in_restart reloads x=0, y=radius first.
// The step yields eight symmetric points on the out_ channel
// (out_valid/out_ready), one per cycle while out_ready is high, with out_last on the eighth and
// out_done_res set on all eight once x has passed y.
// The cfg_ port writes center_x, center_y and radius on any cycle with
// cfg_we high; write them only while the block is idle.
// Path: a taken request is written into the step queue, then popped into
// the step register of the back part; each point passes the output register.
// Throughput: set by the result port, which carries one point per cycle
// while out_ready is high. A two-entry step queue plus the step being
// drawn let up to three requests be taken ahead of the results.
// When the receiver stalls, the shown point holds and the queue fills,
// after which in_ready drops. Reset (rst_n low, synchronous) clears the
// arc state, the configuration registers and all pending work.
// ----------------------------------------------------------------------------
module midpoint_circle_octant_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mcos_pkg::PIX_W-1:0]   out_pixel_x,
  output logic signed [mcos_pkg::PIX_W-1:0]   out_pixel_y,
  output logic                                out_last,
  output logic                                out_done_res,
  input  logic                                cfg_we,
  input  logic [mcos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcos_pkg::CFG_W-1:0]          cfg_data
);

  logic [mcos_pkg::CENTER_W-1:0] center_x_r;
  logic [mcos_pkg::CENTER_W-1:0] center_y_r;
  logic [mcos_pkg::RADIUS_W-1:0] radius_r;

  logic            push_valid, push_ready;
  mcos_pkg::step_t push_data;
  logic            pop_valid, pop_ready;
  mcos_pkg::step_t pop_data;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcos_pkg::REG_CENTER_X: center_x_r <= cfg_data[mcos_pkg::CENTER_W-1:0];
        mcos_pkg::REG_CENTER_Y: center_y_r <= cfg_data[mcos_pkg::CENTER_W-1:0];
        mcos_pkg::REG_RADIUS:   radius_r   <= cfg_data[mcos_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Step classification and state update.
  mcos_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .radius     (radius_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue of steps waiting to be drawn.
  mcos_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Point emission.
  mcos_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_last     (out_last),
    .out_done_res (out_done_res)
  );

endmodule

// ===== tb/sv/circle_point_checker.sv =====
// ----------------------------------------------------------------------------
// circle_point_checker
// Watches the request, result and register ports of the midpoint circle
// octant stepper. It keeps its own copy of the arc state and the registers,
// predicts the eight symmetric points of every accepted request and compares
// each accepted result, field by field, with the oldest predicted point.
// ----------------------------------------------------------------------------
module circle_point_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_restart,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [mcos_pkg::PIX_W-1:0] out_pixel_x,
  input  logic signed [mcos_pkg::PIX_W-1:0] out_pixel_y,
  input  logic                              out_last,
  input  logic                              out_done_res,
  input  logic                              cfg_we,
  input  logic [mcos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcos_pkg::CFG_W-1:0]        cfg_data,
  output int                                fail_count,
  output int                                pending_points
);
  timeunit 1ns;
  timeprecision 1ps;

  import mcos_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             done;
  } circle_point_t;

  // Register copies.
  logic [CENTER_W-1:0]   center_x_reg;
  logic [CENTER_W-1:0]   center_y_reg;
  logic [RADIUS_W-1:0]   radius_reg;

  // Arc state: octant offset and the decision variable scaled by four.
  logic [COORD_BITS-1:0] arc_x;
  logic [COORD_BITS-1:0] arc_y;
  logic [DEC_W-1:0]      arc_d;

  circle_point_t         expected_points[$];
  int                    mismatches;
  int                    points_checked;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: point %0d: %s", $time, points_checked, msg);
  endtask

  // Works out the eight points of one request, then advances the arc.
  task automatic predict_octant_points(input logic restart);
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [PIX_W-1:0]      cxp;
    logic [PIX_W-1:0]      cyp;
    logic [PIX_W-1:0]      xp;
    logic [PIX_W-1:0]      yp;
    logic [PIX_W-1:0]      hx[8];
    logic [PIX_W-1:0]      vy[8];
    logic                  finished;
    circle_point_t         pt;

    if (restart) begin
      arc_x = '0;
      arc_y = COORD_BITS'(radius_reg);
      arc_d = DEC_W'(5) - (DEC_W'(arc_y) << 2);
    end
    x = arc_x;
    y = arc_y;

    // A positive decision moves y inward first; x always moves outward.
    if ($signed(arc_d) > 0) begin
      arc_y = arc_y - 1'b1;
      arc_d = arc_d - (DEC_W'(arc_y) << 3);
    end
    arc_x = arc_x + 1'b1;
    arc_d = arc_d + (DEC_W'(arc_x) << 3) + DEC_W'(4);
    finished = arc_x > arc_y;

    // Coordinates wrap to the pixel width, so plain modular sums are exact.
    cxp = PIX_W'(center_x_reg);
    cyp = PIX_W'(center_y_reg);
    xp  = PIX_W'(x);
    yp  = PIX_W'(y);
    hx[0] = cxp + xp;  vy[0] = cyp - yp;
    hx[1] = cxp - xp;  vy[1] = cyp - yp;
    hx[2] = cxp + xp;  vy[2] = cyp + yp;
    hx[3] = cxp - xp;  vy[3] = cyp + yp;
    hx[4] = cxp + yp;  vy[4] = cyp - xp;
    hx[5] = cxp - yp;  vy[5] = cyp - xp;
    hx[6] = cxp + yp;  vy[6] = cyp + xp;
    hx[7] = cxp - yp;  vy[7] = cyp + xp;
    for (int k = 0; k <= int'(LAST_POINT); k++) begin
      pt.px   = hx[k];
      pt.py   = vy[k];
      pt.last = (k == int'(LAST_POINT));
      pt.done = finished;
      expected_points.push_back(pt);
    end
  endtask

  // Results are checked before the same edge's request is predicted; a
  // request never yields a point at the edge that accepts it.
  always @(posedge clk) begin
    circle_point_t want;

    if (!rst_n) begin
      center_x_reg = '0;
      center_y_reg = '0;
      radius_reg   = '0;
      arc_x        = '0;
      arc_y        = '0;
      arc_d        = '0;
      expected_points.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_points.pop_front();
          if (out_pixel_x !== want.px) begin
            report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                      out_pixel_x, $signed(want.px)));
          end
          if (out_pixel_y !== want.py) begin
            report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                      out_pixel_y, $signed(want.py)));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
          end
          if (out_done_res !== want.done) begin
            report_mismatch($sformatf("done_res %b, expected %b",
                                      out_done_res, want.done));
          end
        end
        points_checked++;
      end

      // Register writes; an unused index changes nothing.
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X: center_x_reg = cfg_data[CENTER_W-1:0];
          REG_CENTER_Y: center_y_reg = cfg_data[CENTER_W-1:0];
          REG_RADIUS:   radius_reg   = cfg_data[RADIUS_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        predict_octant_points(in_restart);
      end
    end

    fail_count     <= mismatches;
    pending_points <= expected_points.size();
  end

endmodule

// ===== tb/sv/midpoint_circle_octant_step_test.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_octant_step_test
// Drives step requests and register writes into the midpoint circle octant
// stepper: a directed opening over the extreme centers and radii, wrapping
// arcs and stepping past completion, then random arcs under random request
// gaps and result stalls. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module midpoint_circle_octant_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcos_pkg::*;

  // Index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 380;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int DRAIN_CYCLES    = 24;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic                    in_restart = 1'b0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic signed [PIX_W-1:0] out_pixel_x;
  logic signed [PIX_W-1:0] out_pixel_y;
  logic                    out_last;
  logic                    out_done_res;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_W-1:0]        cfg_data   = '0;

  int   fail_count;
  int   pending_points;
  int   sent;
  int   calm_from = 32'h7fff_ffff;
  logic calm = 1'b0;
  int   gap_pct;
  int   stall_pct;
  int   quiet_cycles;

  midpoint_circle_octant_step DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_last     (out_last),
    .out_done_res (out_done_res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  circle_point_checker point_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last       (out_last),
    .out_done_res   (out_done_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_points (pending_points)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready, broken by stall bursts of random length.
  initial begin
    forever begin
      if (!calm && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one step request, sometimes after a gap, and waits for its
  // acceptance. Valid stays high afterwards so back-to-back requests
  // need no second assignment in the same step.
  task automatic send_request(input logic restart);
    if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    calm = (sent >= calm_from);
  endtask

  // Drops valid and waits until every predicted point has come out.
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes all three registers back to back, optionally with a stray write.
  task automatic load_circle(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                             input logic [CFG_W-1:0] rad, input logic stray);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CENTER_X;
    cfg_data  <= cx;
    @(posedge clk);
    cfg_index <= REG_CENTER_Y;
    cfg_data  <= cy;
    @(posedge clk);
    cfg_index <= REG_RADIUS;
    cfg_data  <= rad;
    @(posedge clk);
    if (stray) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= CFG_W'($urandom_range(0, 4095));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_center();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_W'({CENTER_W{1'b1}});
      default: return CFG_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int pick_pct(input int busy);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return busy / 3;
      default: return busy;
    endcase
  endfunction

  initial begin
    int               r;
    int               steps;
    int               kind;
    int               random_from;
    logic [CFG_W-1:0] rdata;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Stepping straight out of reset, with no restart, starts from the
    // all-zero arc.
    gap_pct   = 20;
    stall_pct = 8;
    repeat (3) send_request(1'b0);

    // Largest centers and radius; the top bit of the radius write is masked.
    settle(SETTLE_CYCLES);
    load_circle('1, '1, '1, 1'b1);
    send_request(1'b1);
    repeat (3) send_request(1'b0);

    // Radius zero at the origin: the first step pulls y below zero, so it
    // wraps to the top of its range and the points go negative.
    settle(SETTLE_CYCLES);
    load_circle('0, '0, '0, 1'b0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);

    // Only the masked radius bit set, at the far corner: the wrapped offset
    // drives the coordinates close to the top of the pixel range.
    settle(SETTLE_CYCLES);
    load_circle('1, '1, {1'b1, {RADIUS_W{1'b0}}}, 1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // A small circle stepped through completion and beyond it.
    settle(SETTLE_CYCLES);
    load_circle('1, '0, CFG_W'(5), 1'b0);
    send_request(1'b1);
    repeat (5) send_request(1'b0);

    // Random phases: new registers, new idling, then a few arcs each. The
    // last part of the run has no idling at all.
    random_from = sent;
    calm_from   = sent + RANDOM_REQUESTS * 85 / 100;
    while (sent < random_from + RANDOM_REQUESTS) begin
      settle(SETTLE_CYCLES);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        r = $urandom_range(0, 40);
      end else if (kind < 9) begin
        r = $urandom_range(41, 200);
      end else begin
        r = ($urandom_range(0, 1) == 1) ? 2047 : $urandom_range(201, 2047);
      end
      rdata = CFG_W'(r);
      rdata[CFG_W-1] = 1'($urandom_range(0, 1));
      load_circle(pick_center(), pick_center(), rdata, $urandom_range(0, 3) == 0);
      gap_pct   = pick_pct(45);
      stall_pct = pick_pct(20);

      repeat ($urandom_range(2, 4)) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // Whole arc, ending at or a little past completion; large radii
          // are only started.
          if (r > 200) begin
            steps = $urandom_range(4, 24);
          end else begin
            steps = (r * 707) / 1000 + $urandom_range(1, 4);
          end
          send_request(1'b1);
          repeat (steps) send_request(1'b0);
        end else if (kind < 9) begin
          // Noise: restarts at random points.
          repeat ($urandom_range(3, 12)) send_request($urandom_range(0, 3) == 0);
        end else begin
          // Arc cut short by the next sequence's restart.
          send_request(1'b1);
          repeat ($urandom_range(0, 3)) send_request(1'b0);
        end
      end
    end

    settle(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
